FILE: src/rpk_pkg.sv
// rpk_pkg: shared widths, codes and types of the region page key translator
// no dependencies; imported by every other file of the block
`default_nettype none

package rpk_pkg;

	localparam int NUM_REGIONS = 8;
	localparam int ADDR_BITS   = 48;
	localparam int RIDX_W      = $clog2(NUM_REGIONS);

	localparam int OP_W       = 2;
	localparam int REGION_W   = 3;
	localparam int PAGE_W     = 36;
	localparam int TADDR_W    = 49;
	localparam int SHIFT_W    = 5;
	localparam int ACT_W      = 4;
	localparam int OFF_W      = PAGE_W + (2 ** SHIFT_W) - 1;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE     = 1'd1;

	localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RST = 5'd12;
	localparam logic [ACT_W-1:0]   ACTIVE_RST     = 4'd0;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD = 2'd0,
		OP_A2K  = 2'd1,
		OP_K2A  = 2'd2,
		OP_RSVD = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		K_NONE,
		K_LOAD,
		K_A2K,
		K_K2A
	} kind_t;

	typedef struct packed {
		logic [SHIFT_W-1:0] page_shift;
		logic [ACT_W-1:0]   active;
	} cfg_t;

	// aux holds the region length for a load and the byte offset for key to address
	typedef struct packed {
		kind_t                 kind;
		logic [REGION_W-1:0]   idx;
		logic [ADDR_BITS-1:0]  addr;
		logic [ADDR_BITS-1:0]  aux;
	} item_t;

endpackage

`default_nettype wire

FILE: src/rpk_ifs.sv
// rpk_ifs: request, response and configuration channel interfaces
// depends on rpk_pkg for field widths
`default_nettype none

interface rpk_in_if
	import rpk_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [OP_W-1:0]       opcode;
	logic [REGION_W-1:0]   region_index;
	logic [ADDR_BITS-1:0]  address;
	logic [ADDR_BITS-1:0]  region_length;
	logic [PAGE_W-1:0]     page_number;

	modport source (output valid, opcode, region_index, address, region_length, page_number,
		input ready);
	modport sink (input valid, opcode, region_index, address, region_length, page_number,
		output ready);
endinterface

interface rpk_out_if
	import rpk_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic                  found;
	logic [REGION_W-1:0]   hit_region;
	logic [PAGE_W-1:0]     hit_page;
	logic [TADDR_W-1:0]    translated_address;

	modport source (output valid, found, hit_region, hit_page, translated_address,
		input ready);
	modport sink (input valid, found, hit_region, hit_page, translated_address,
		output ready);
endinterface

interface rpk_cfg_if
	import rpk_pkg::*;
();
	logic                   valid;
	logic                   ready;
	logic [CFG_IDX_W-1:0]   index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: src/rpk_front.sv
// rpk_front: configuration registers and request classification
// depends on rpk_pkg and rpk_ifs; feeds rpk_queue
`default_nettype none

module rpk_front
	import rpk_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	rpk_in_if.sink     req,
	rpk_cfg_if.sink    cfg,
	output cfg_t       cfg_o,
	output logic       push,
	output item_t      push_item,
	input  wire logic  push_ready
);

	logic [SHIFT_W-1:0] page_shift_q;
	logic [ACT_W-1:0]   active_q;
	logic [OFF_W-1:0]   off_full;
	logic               off_fits;
	logic               in_active;
	logic               load_ok;

	assign cfg.ready = 1'b1;
	assign cfg_o.page_shift = page_shift_q;
	assign cfg_o.active = active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_shift_q <= PAGE_SHIFT_RST;
			active_q <= ACTIVE_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_PAGE_SHIFT: page_shift_q <= cfg.data[SHIFT_W-1:0];
				CFG_ACTIVE: active_q <= cfg.data[ACT_W-1:0];
				default: ;
			endcase
		end
	end

	assign req.ready = push_ready;
	assign push = req.valid;

	// page offset in bytes, too wide for any region length means a miss
	assign off_full = OFF_W'(req.page_number) << page_shift_q;
	assign off_fits = (off_full[OFF_W-1:ADDR_BITS] == '0);
	assign in_active = ((ACT_W + 1)'(req.region_index) < (ACT_W + 1)'(active_q));
	assign load_ok = (32'(req.region_index) < NUM_REGIONS);

	always_comb begin
		push_item.idx = req.region_index;
		push_item.addr = req.address;
		push_item.aux = req.region_length;
		push_item.kind = K_NONE;
		case (opcode_t'(req.opcode))
			OP_LOAD: push_item.kind = load_ok ? K_LOAD : K_NONE;
			OP_A2K: push_item.kind = K_A2K;
			OP_K2A: begin
				push_item.kind = (in_active && off_fits) ? K_K2A : K_NONE;
				push_item.aux = off_full[ADDR_BITS-1:0];
			end
			default: push_item.kind = K_NONE;
		endcase
	end

endmodule

`default_nettype wire

FILE: src/rpk_queue.sv
// rpk_queue: two-entry queue between the classifying front and the table back end
// depends on rpk_pkg
`default_nettype none

module rpk_queue
	import rpk_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire item_t  push_item,
	output logic        push_ready,
	output logic        pop_valid,
	output item_t       pop_item,
	input  wire logic   pop
);

	item_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_q;
	logic [QPTR_W-1:0]  rd_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (cnt_q != QCNT_W'(QDEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_item = mem_q[rd_q];
	assign do_push = push && push_ready;
	assign do_pop = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (32'(wr_q) == QDEPTH - 1) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (32'(rd_q) == QDEPTH - 1) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

FILE: src/rpk_back.sv
// rpk_back: region table, parallel match stage and registered response
// depends on rpk_pkg and rpk_ifs; drained from rpk_queue
`default_nettype none

module rpk_back
	import rpk_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire cfg_t   cfg_i,
	input  wire logic   pop_valid,
	input  wire item_t  pop_item,
	output logic        pop,
	rpk_out_if.source   rsp
);

	logic [ADDR_BITS-1:0] base_q [NUM_REGIONS];
	logic [ADDR_BITS-1:0] size_q [NUM_REGIONS];

	logic                  v_s1;
	kind_t                 kind_s1;
	logic                  found_s1;
	logic [REGION_W-1:0]   region_s1;
	logic [ADDR_BITS-1:0]  opa_s1;
	logic [ADDR_BITS-1:0]  opb_s1;

	logic                  out_v_q;
	logic                  found_q;
	logic [REGION_W-1:0]   region_q;
	logic [PAGE_W-1:0]     page_q;
	logic [TADDR_W-1:0]    taddr_q;

	logic                  out_free;
	logic                  s1_free;
	logic [NUM_REGIONS-1:0] match;
	logic                  any_hit;
	logic [RIDX_W-1:0]     hit_idx;
	logic [RIDX_W-1:0]     tidx;
	logic                  k2a_hit;
	logic                  n_found;
	logic [REGION_W-1:0]   n_region;
	logic [ADDR_BITS-1:0]  n_opa;
	logic [ADDR_BITS-1:0]  n_opb;
	logic [ADDR_BITS-1:0]  diff;
	logic [ADDR_BITS-1:0]  sum;
	logic [ADDR_BITS-1:0]  diff_sh;

	assign out_free = !out_v_q || rsp.ready;
	assign s1_free = !v_s1 || out_free;
	assign pop = pop_valid && s1_free;
	assign tidx = RIDX_W'(pop_item.idx);

	// every active region compared at once
	always_comb begin
		for (int i = 0; i < NUM_REGIONS; i++) begin
			match[i] = (i < int'(cfg_i.active))
				&& (pop_item.addr >= base_q[i])
				&& ({1'b0, pop_item.addr} < ({1'b0, base_q[i]} + {1'b0, size_q[i]}));
		end
	end

	// lowest-numbered match wins
	always_comb begin
		any_hit = 1'b0;
		hit_idx = '0;
		for (int i = NUM_REGIONS - 1; i >= 0; i--) begin
			if (match[i]) begin
				any_hit = 1'b1;
				hit_idx = RIDX_W'(i);
			end
		end
	end

	assign k2a_hit = (pop_item.aux < size_q[tidx]);

	always_comb begin
		n_found = 1'b0;
		n_region = '0;
		n_opa = pop_item.addr;
		n_opb = base_q[hit_idx];
		case (pop_item.kind)
			K_LOAD: n_found = 1'b1;
			K_A2K: begin
				n_found = any_hit;
				n_region = any_hit ? REGION_W'(hit_idx) : '0;
			end
			K_K2A: begin
				n_found = k2a_hit;
				n_opa = base_q[tidx];
				n_opb = pop_item.aux;
			end
			default: n_found = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop && pop_item.kind == K_LOAD) begin
			base_q[tidx] <= pop_item.addr;
			size_q[tidx] <= pop_item.aux;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_free) begin
			v_s1 <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_s1 <= pop_item.kind;
			found_s1 <= n_found;
			region_s1 <= n_region;
			opa_s1 <= n_opa;
			opb_s1 <= n_opb;
		end
	end

	assign diff = opa_s1 - opb_s1;
	assign sum = opa_s1 + opb_s1;
	assign diff_sh = diff >> cfg_i.page_shift;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && v_s1) begin
			found_q <= found_s1;
			region_q <= region_s1;
			page_q <= (kind_s1 == K_A2K && found_s1) ? diff_sh[PAGE_W-1:0] : '0;
			taddr_q <= (kind_s1 == K_K2A && found_s1) ? TADDR_W'(sum) : '0;
		end
	end

	assign rsp.valid = out_v_q;
	assign rsp.found = found_q;
	assign rsp.hit_region = region_q;
	assign rsp.hit_page = page_q;
	assign rsp.translated_address = taddr_q;

endmodule

`default_nettype wire

FILE: src/region_page_key_translator_unit.sv
// region_page_key_translator_unit: top level of the region page key translator
// depends on rpk_pkg, rpk_ifs, rpk_front, rpk_queue and rpk_back
//
// channels: req carries one request (opcode, region_index, address, region_length,
// page_number); rsp returns exactly one response per request, in order; cfg writes
// page_shift (index 0) or active_regions (index 1), always ready
// opcode 0 loads a table entry, 1 maps an address to (region, page), 2 maps
// (region, page) back to an address; a miss or opcode 3 gives found low, all zero
// path: queue entry, match stage register, response register; throughput is one
// request per cycle while rsp is ready, set by the single match stage that compares
// all eight regions in parallel and the two-entry queue before it
// reset: queue and pipeline empty, page_shift 12, active_regions 0; table
// contents are undefined until loaded
// stall: a held response freezes the back end; req.ready drops once the two-entry
// queue is full, so up to four requests wait inside
`default_nettype none

module region_page_key_translator_unit
	import rpk_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	rpk_in_if.sink     req,
	rpk_cfg_if.sink    cfg,
	rpk_out_if.source  rsp
);

	cfg_t   cfg_cur;
	logic   push;
	item_t  push_item;
	logic   push_ready;
	logic   pop_valid;
	item_t  pop_item;
	logic   pop;

	rpk_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.cfg        (cfg),
		.cfg_o      (cfg_cur),
		.push       (push),
		.push_item  (push_item),
		.push_ready (push_ready)
	);

	rpk_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item),
		.pop        (pop)
	);

	rpk_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_i     (cfg_cur),
		.pop_valid (pop_valid),
		.pop_item  (pop_item),
		.pop       (pop),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

FILE: src/rpk_checker.sv
// rpk_checker: port-level assertions for the region page key translator
// depends on rpk_pkg; bound to region_page_key_translator_unit
`default_nettype none

module rpk_checker
	import rpk_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 rsp_valid,
	input wire logic                 rsp_ready,
	input wire logic                 rsp_found,
	input wire logic [REGION_W-1:0]  rsp_hit_region,
	input wire logic [PAGE_W-1:0]    rsp_hit_page,
	input wire logic [TADDR_W-1:0]   rsp_taddr
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found)
			&& $stable(rsp_hit_region) && $stable(rsp_hit_page) && $stable(rsp_taddr))
		else $error("response changed while stalled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_found |-> rsp_hit_region == '0 && rsp_hit_page == '0
			&& rsp_taddr == '0)
		else $error("miss with nonzero fields");

	a_one_direction: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_taddr == '0 || (rsp_hit_region == '0 && rsp_hit_page == '0))
		else $error("key and address both set");

	a_taddr_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !rsp_taddr[TADDR_W-1])
		else $error("translated address beyond address width");

endmodule

bind region_page_key_translator_unit rpk_checker u_rpk_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_found      (rsp.found),
	.rsp_hit_region (rsp.hit_region),
	.rsp_hit_page   (rsp.hit_page),
	.rsp_taddr      (rsp.translated_address)
);

`default_nettype wire

FILE: test/rpk_translation_checker.sv
// rpk_translation_checker: watches the request, response and register channels of the
// region page key translator, predicts each response and compares it field by field
// depends on rpk_pkg and the channel interfaces in rpk_ifs
`default_nettype none

module rpk_translation_checker
	import rpk_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	rpk_in_if         req,
	rpk_cfg_if        cfg,
	rpk_out_if        rsp,
	output int        errors,
	output int        outstanding,
	output int        checked,
	output int        xlate_hits,
	output int        xlate_misses
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                 found;
		logic [REGION_W-1:0]  hit_region;
		logic [PAGE_W-1:0]    hit_page;
		logic [TADDR_W-1:0]   taddr;
	} xlate_result_t;

	logic [ADDR_BITS-1:0] region_start [NUM_REGIONS];
	logic [ADDR_BITS-1:0] region_span [NUM_REGIONS];
	logic [SHIFT_W-1:0]   shift;
	logic [ACT_W-1:0]     act_regions;

	xlate_result_t pending_results [$];
	int fail_tally, compared, hit_tally, miss_tally;

	// table loads take effect here, in request order
	function automatic xlate_result_t translate_request(logic [OP_W-1:0] op,
		logic [REGION_W-1:0] idx, logic [ADDR_BITS-1:0] addr,
		logic [ADDR_BITS-1:0] len, logic [PAGE_W-1:0] page);
		xlate_result_t res;
		logic [ADDR_BITS:0] lim;
		logic [ADDR_BITS-1:0] delta, sum;
		logic [PAGE_W+31:0] off;
		int n;
		res = '0;
		n = (int'(act_regions) > NUM_REGIONS) ? NUM_REGIONS : int'(act_regions);
		case (opcode_t'(op))
			OP_LOAD: begin
				region_start[idx] = addr;
				region_span[idx] = len;
				res.found = 1'b1;
			end
			OP_A2K: begin
				for (int i = 0; i < n; i++) begin
					lim = {1'b0, region_start[i]} + {1'b0, region_span[i]};
					if (!res.found && addr >= region_start[i] && {1'b0, addr} < lim) begin
						delta = addr - region_start[i];
						res.found = 1'b1;
						res.hit_region = REGION_W'(i);
						res.hit_page = PAGE_W'(delta >> shift);
					end
				end
			end
			OP_K2A: begin
				if (int'(idx) < n) begin
					off = {32'b0, page} << shift;
					if (off < {20'b0, region_span[idx]}) begin
						sum = region_start[idx] + off[ADDR_BITS-1:0];
						res.found = 1'b1;
						res.taddr = {1'b0, sum};
					end
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		xlate_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGIONS; i++) begin
				region_start[i] = '0;
				region_span[i] = '0;
			end
			shift = PAGE_SHIFT_RST;
			act_regions = ACTIVE_RST;
			pending_results.delete();
			fail_tally = 0;
			compared = 0;
			hit_tally = 0;
			miss_tally = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (pending_results.size() == 0) begin
					$error("response with no request outstanding");
					fail_tally++;
				end else begin
					want = pending_results.pop_front();
					compared++;
					if (rsp.found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, rsp.found);
						fail_tally++;
					end
					if (rsp.hit_region !== want.hit_region) begin
						$error("hit_region: expected %0d, got %0d", want.hit_region,
							rsp.hit_region);
						fail_tally++;
					end
					if (rsp.hit_page !== want.hit_page) begin
						$error("hit_page: expected %0h, got %0h", want.hit_page, rsp.hit_page);
						fail_tally++;
					end
					if (rsp.translated_address !== want.taddr) begin
						$error("translated_address: expected %0h, got %0h", want.taddr,
							rsp.translated_address);
						fail_tally++;
					end
				end
			end
			if (req.valid && req.ready) begin
				want = translate_request(req.opcode, req.region_index, req.address,
					req.region_length, req.page_number);
				pending_results.push_back(want);
				if (req.opcode == OP_A2K || req.opcode == OP_K2A) begin
					if (want.found)
						hit_tally++;
					else
						miss_tally++;
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_PAGE_SHIFT: shift = cfg.data[SHIFT_W-1:0];
					CFG_ACTIVE: act_regions = cfg.data[ACT_W-1:0];
					default: ;
				endcase
			end
		end
		errors <= fail_tally;
		outstanding <= pending_results.size();
		checked <= compared;
		xlate_hits <= hit_tally;
		xlate_misses <= miss_tally;
	end

endmodule

`default_nettype wire

FILE: test/region_page_key_translator_unit_test.sv
// region_page_key_translator_unit_test: drives loads and translations in both directions
// under several page shift and active count settings, with random stalls on both sides
// depends on rpk_pkg, rpk_ifs, the translator and rpk_translation_checker
`default_nettype none

module region_page_key_translator_unit_test
	import rpk_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;

	rpk_in_if  req_ch ();
	rpk_out_if rsp_ch ();
	rpk_cfg_if cfg_ch ();

	int errors, outstanding, checked, xlate_hits, xlate_misses;

	region_page_key_translator_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.cfg    (cfg_ch),
		.rsp    (rsp_ch)
	);

	rpk_translation_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req_ch),
		.cfg          (cfg_ch),
		.rsp          (rsp_ch),
		.errors       (errors),
		.outstanding  (outstanding),
		.checked      (checked),
		.xlate_hits   (xlate_hits),
		.xlate_misses (xlate_misses)
	);

	// shadow of the table, used only to aim addresses and pages
	logic [ADDR_BITS-1:0] tbase [NUM_REGIONS];
	logic [ADDR_BITS-1:0] tlen [NUM_REGIONS];
	logic [SHIFT_W-1:0]   cur_shift;
	int settings_used;
	bit tx_fast, rx_fast;
	int rx_wait = 3;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic logic [ADDR_BITS-1:0] rand48();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[ADDR_BITS-1:0];
	endfunction

	function automatic logic [PAGE_W-1:0] rand36();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[PAGE_W-1:0];
	endfunction

	task automatic issue_request(input opcode_t op, input logic [REGION_W-1:0] idx,
		input logic [ADDR_BITS-1:0] addr, input logic [ADDR_BITS-1:0] len,
		input logic [PAGE_W-1:0] page);
		int gap;
		gap = tx_fast ? 0 : $urandom_range(0, 15);
		if ($urandom_range(0, 49) == 0)
			tx_fast = !tx_fast;
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.region_index <= idx;
		req_ch.address <= addr;
		req_ch.region_length <= len;
		req_ch.page_number <= page;
		do @(posedge clk); while (!req_ch.ready);
		if (op == OP_LOAD) begin
			tbase[idx] = addr;
			tlen[idx] = len;
		end
	endtask

	// hold off until every request has its response
	task automatic settle();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_settings(input logic [SHIFT_W-1:0] shift, input int active);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= CFG_PAGE_SHIFT;
		cfg_ch.data <= CFG_DATA_W'(shift);
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.index <= CFG_ACTIVE;
		cfg_ch.data <= CFG_DATA_W'(active);
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		cur_shift = shift;
		settings_used++;
	endtask

	task automatic random_request();
		int sel, r;
		opcode_t op;
		logic [REGION_W-1:0] idx;
		logic [ADDR_BITS-1:0] a, l, span;
		logic [PAGE_W-1:0] p;
		sel = $urandom_range(0, 99);
		op = (sel < 12) ? OP_LOAD : (sel < 55) ? OP_A2K : (sel < 96) ? OP_K2A : OP_RSVD;
		idx = REGION_W'($urandom_range(0, NUM_REGIONS - 1));
		a = rand48();
		l = rand48();
		p = rand36();
		case (op)
			OP_LOAD: begin
				case ($urandom_range(0, 5))
					0: l = '0;
					1: l = ADDR_BITS'($urandom_range(1, 1 << 16));
					2: l = {16'b0, $urandom()};
					3: l = ADDR_BITS'($urandom_range(1, 64)) << cur_shift;
					4: a = '1 - ADDR_BITS'($urandom_range(0, 1 << 20));
					default: ;
				endcase
				if ($urandom_range(0, 3) == 0)
					a = tbase[$urandom_range(0, NUM_REGIONS - 1)]
						+ ADDR_BITS'($urandom_range(0, 4095));
			end
			OP_A2K: begin
				r = $urandom_range(0, NUM_REGIONS - 1);
				case ($urandom_range(0, 6))
					0: a = tbase[r];
					1: a = tbase[r] + tlen[r] - 1'b1;
					2: a = tbase[r] + tlen[r];
					3: a = tbase[r] - 1'b1;
					4, 5: if (tlen[r] != 0) a = tbase[r] + rand48() % tlen[r];
					default: ;
				endcase
			end
			OP_K2A: begin
				span = tlen[idx] >> cur_shift;
				case ($urandom_range(0, 5))
					0: p = '0;
					1: p = span[PAGE_W-1:0];
					2: p = span[PAGE_W-1:0] - 1'b1;
					3, 4: if (span != 0) p = PAGE_W'(rand48() % span);
					default: ;
				endcase
			end
			default: ;
		endcase
		issue_request(op, idx, a, l, p);
	endtask

	// response side: random stall after each response, with stall-free stretches
	always @(posedge clk) begin
		int w;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				w = rx_fast ? 0 : $urandom_range(0, 15);
				if ($urandom_range(0, 49) == 0)
					rx_fast <= !rx_fast;
				rx_wait <= w;
				rsp_ch.ready <= (w == 0);
			end else if (rx_wait > 0) begin
				rx_wait <= rx_wait - 1;
				rsp_ch.ready <= (rx_wait == 1);
			end
		end
	end

	initial begin
		logic [SHIFT_W-1:0] shifts [4];
		int actives [4];
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_LOAD;
		req_ch.region_index = '0;
		req_ch.address = '0;
		req_ch.region_length = '0;
		req_ch.page_number = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_PAGE_SHIFT;
		cfg_ch.data = '0;
		rsp_ch.ready = 1'b0;
		cur_shift = PAGE_SHIFT_RST;
		settings_used = 0;
		tx_fast = 1'b0;
		rx_fast = 1'b0;
		shifts = '{5'd12, 5'd21, 5'd21, 5'd12};
		actives = '{8, 8, 0, 3};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the whole table before any entry takes part in matching
		issue_request(OP_LOAD, 3'd0, 48'h0000_1000_0000, 48'h0000_0010_0000, '0);
		issue_request(OP_LOAD, 3'd1, 48'h0000_1000_8000, 48'h0000_0100_0000, '0);
		issue_request(OP_LOAD, 3'd2, '0, '0, '0);
		issue_request(OP_LOAD, 3'd3, 48'hFFFF_FFFF_F000, '1, '0);
		issue_request(OP_LOAD, 3'd4, '0, '1, '0);
		issue_request(OP_LOAD, 3'd5, '1, 48'd1, '0);
		issue_request(OP_LOAD, 3'd6, rand48(), {16'b0, $urandom()}, '0);
		issue_request(OP_LOAD, 3'd7, rand48(), 48'($urandom_range(1, 1 << 20)), '0);
		settle();
		write_settings(5'd12, 8);

		issue_request(OP_A2K, 3'd0, 48'h0000_1000_0000, '0, '0);
		issue_request(OP_A2K, 3'd0, 48'h0000_1000_8000, '0, '0);
		issue_request(OP_A2K, 3'd0, 48'h0000_100F_FFFF, '0, '0);
		issue_request(OP_A2K, 3'd0, 48'h0000_1010_0000, '0, '0);
		issue_request(OP_A2K, 3'd0, '1, '0, '0);
		issue_request(OP_A2K, 3'd0, '0, '0, '0);
		issue_request(OP_K2A, 3'd0, '0, '0, '0);
		issue_request(OP_K2A, 3'd0, '0, '0, 36'h0FF);
		issue_request(OP_K2A, 3'd0, '0, '0, 36'h100);
		issue_request(OP_K2A, 3'd2, '0, '0, '0);
		issue_request(OP_K2A, 3'd3, '0, '0, 36'h10);
		issue_request(OP_K2A, 3'd4, '0, '0, '1);
		issue_request(OP_RSVD, '1, '1, '1, '1);
		issue_request(OP_LOAD, '1, '1, '1, '1);
		issue_request(OP_K2A, 3'd7, '0, '0, '1);
		settle();
		write_settings(5'd21, 0);
		issue_request(OP_A2K, 3'd0, 48'h0000_1000_0000, '0, '0);
		issue_request(OP_K2A, 3'd0, '0, '0, '0);

		for (int ph = 0; ph < 10; ph++) begin
			settle();
			if (ph < 4)
				write_settings(shifts[ph], actives[ph]);
			else
				write_settings(SHIFT_W'($urandom_range(12, 21)), $urandom_range(0, 8));
			repeat (130) random_request();
		end

		settle();
		repeat (8) @(posedge clk);
		$display("checked %0d responses across %0d register settings", checked, settings_used);
		$display("translations: %0d hits, %0d misses", xlate_hits, xlate_misses);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire

FILE: region_page_key_translator_unit.f
src/rpk_pkg.sv
src/rpk_ifs.sv
src/rpk_front.sv
src/rpk_queue.sv
src/rpk_back.sv
src/region_page_key_translator_unit.sv
src/rpk_checker.sv
test/rpk_translation_checker.sv
test/region_page_key_translator_unit_test.sv
